// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers for the RTL; they expand to nothing
// when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// The property must hold at every rising clock edge outside reset.
`define RO_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// When the antecedent holds, the consequent holds in the same cycle.
`define RO_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// When the antecedent holds, the consequent holds in the next cycle.
`define RO_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define RO_ASSERT(lbl, clk, rst_n, prop, msg)
`define RO_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define RO_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/rect_ov_pkg.sv =====
// ----------------------------------------------------------------------------
// Rectangle outline overlay package
// Field widths, register offsets, reset values and shared types.
// ----------------------------------------------------------------------------
package rect_ov_pkg;

	// Default configuration of the block.
	localparam int NUM_RECTS_DEF  = 4;
	localparam int COORD_BITS_DEF = 13;

	// Fixed field widths.
	localparam int PIX_BITS   = 12;
	localparam int CHAN_BITS  = 8;
	localparam int COLOR_BITS = 24;
	localparam int PEN_BITS   = 6;
	localparam int FRAME_BITS = 13;

	// Register offsets after the rectangle registers.
	localparam int CFG_OFS_COLOR  = 0;
	localparam int CFG_OFS_PEN    = 1;
	localparam int CFG_OFS_WIDTH  = 2;
	localparam int CFG_OFS_HEIGHT = 3;
	localparam int CFG_NUM_SHARED = 4;

	// Reset values.
	localparam logic [COLOR_BITS-1:0] COLOR_RESET  = 24'h00FF00;
	localparam logic [PEN_BITS-1:0]   PEN_RESET    = 6'd4;
	localparam logic [FRAME_BITS-1:0] WIDTH_RESET  = 13'd640;
	localparam logic [FRAME_BITS-1:0] HEIGHT_RESET = 13'd480;

	// Settings shared by all rectangles.
	typedef struct packed {
		logic [COLOR_BITS-1:0] color;
		logic [PEN_BITS-1:0]   pen;
		logic [FRAME_BITS-1:0] width;
		logic [FRAME_BITS-1:0] height;
	} frame_cfg_t;

	function automatic int max_int(input int a, input int b);
		return (a > b) ? a : b;
	endfunction

	function automatic int rect_bits(input int coord_bits);
		return 4 * coord_bits + 1;
	endfunction

	function automatic int cfg_data_bits(input int coord_bits);
		return max_int(rect_bits(coord_bits), COLOR_BITS);
	endfunction

	function automatic int cfg_index_bits(input int num_rects);
		return $clog2(num_rects + CFG_NUM_SHARED);
	endfunction

endpackage

// ===== hw/rtl/rect_ov_if.sv =====
// ----------------------------------------------------------------------------
// Rectangle outline overlay interfaces
// Pixel input, pixel output and configuration write channels.
// ----------------------------------------------------------------------------
interface rect_ov_pix_in_if;
	import rect_ov_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [PIX_BITS-1:0]  pixel_x;
	logic [PIX_BITS-1:0]  pixel_y;
	logic [CHAN_BITS-1:0] blue_in;
	logic [CHAN_BITS-1:0] green_in;
	logic [CHAN_BITS-1:0] red_in;

	modport source (output valid, pixel_x, pixel_y, blue_in, green_in, red_in, input ready);
	modport sink (input valid, pixel_x, pixel_y, blue_in, green_in, red_in, output ready);
endinterface

interface rect_ov_pix_out_if;
	import rect_ov_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [CHAN_BITS-1:0] blue_out;
	logic [CHAN_BITS-1:0] green_out;
	logic [CHAN_BITS-1:0] red_out;
	logic                 on_outline;

	modport source (output valid, blue_out, green_out, red_out, on_outline, input ready);
	modport sink (input valid, blue_out, green_out, red_out, on_outline, output ready);
endinterface

interface rect_ov_cfg_if #(
	parameter int INDEX_BITS = rect_ov_pkg::cfg_index_bits(rect_ov_pkg::NUM_RECTS_DEF),
	parameter int DATA_BITS  = rect_ov_pkg::cfg_data_bits(rect_ov_pkg::COORD_BITS_DEF)
);
	logic                  valid;
	logic                  ready;
	logic [INDEX_BITS-1:0] index;
	logic [DATA_BITS-1:0]  data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/rect_ov_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// Rectangle outline overlay configuration registers
// Holds the rectangle registers and the shared frame settings.
// ----------------------------------------------------------------------------
module rect_ov_cfg_regs #(
	parameter int NUM_RECTS  = rect_ov_pkg::NUM_RECTS_DEF,
	parameter int COORD_BITS = rect_ov_pkg::COORD_BITS_DEF
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	rect_ov_cfg_if.sink                                cfg,
	output logic [NUM_RECTS-1:0][4*COORD_BITS:0]       rects,
	output rect_ov_pkg::frame_cfg_t                    frame
);
	import rect_ov_pkg::*;

	localparam int RECT_BITS = rect_bits(COORD_BITS);
	localparam int IDX_BITS  = cfg_index_bits(NUM_RECTS);

	localparam logic [IDX_BITS-1:0] IDX_COLOR  = IDX_BITS'(NUM_RECTS + CFG_OFS_COLOR);
	localparam logic [IDX_BITS-1:0] IDX_PEN    = IDX_BITS'(NUM_RECTS + CFG_OFS_PEN);
	localparam logic [IDX_BITS-1:0] IDX_WIDTH  = IDX_BITS'(NUM_RECTS + CFG_OFS_WIDTH);
	localparam logic [IDX_BITS-1:0] IDX_HEIGHT = IDX_BITS'(NUM_RECTS + CFG_OFS_HEIGHT);

	logic [NUM_RECTS-1:0][RECT_BITS-1:0] rects_q;
	frame_cfg_t                          frame_q;
	logic                                wr;

	// Writes are always taken.
	assign cfg.ready = 1'b1;
	assign wr        = cfg.valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rects_q        <= '0;
			frame_q.color  <= COLOR_RESET;
			frame_q.pen    <= PEN_RESET;
			frame_q.width  <= WIDTH_RESET;
			frame_q.height <= HEIGHT_RESET;
		end else if (wr) begin
			for (int i = 0; i < NUM_RECTS; i++) begin
				if (cfg.index == IDX_BITS'(i)) begin
					rects_q[i] <= cfg.data[RECT_BITS-1:0];
				end
			end
			// Indexes beyond the register list fall through and are ignored.
			priority if (cfg.index == IDX_COLOR) begin
				frame_q.color <= cfg.data[COLOR_BITS-1:0];
			end else if (cfg.index == IDX_PEN) begin
				frame_q.pen <= cfg.data[PEN_BITS-1:0];
			end else if (cfg.index == IDX_WIDTH) begin
				frame_q.width <= cfg.data[FRAME_BITS-1:0];
			end else if (cfg.index == IDX_HEIGHT) begin
				frame_q.height <= cfg.data[FRAME_BITS-1:0];
			end else begin
				frame_q <= frame_q;
			end
		end
	end

	assign rects = rects_q;
	assign frame = frame_q;

endmodule

// ===== hw/rtl/rect_ov_hit.sv =====
// ----------------------------------------------------------------------------
// Rectangle outline overlay hit test
// Clamps one rectangle to the frame and tests a pixel against its four bands.
// ----------------------------------------------------------------------------
module rect_ov_hit #(
	parameter int COORD_BITS = rect_ov_pkg::COORD_BITS_DEF
) (
	input  logic [4*COORD_BITS:0]              rect,
	input  logic [rect_ov_pkg::PIX_BITS-1:0]   x,
	input  logic [rect_ov_pkg::PIX_BITS-1:0]   y,
	input  rect_ov_pkg::frame_cfg_t            frame,
	output logic                               hit
);
	import rect_ov_pkg::*;

	// Signed working width with headroom for the pen offsets and the clamp.
	localparam int CB = max_int(COORD_BITS, FRAME_BITS) + 3;

	localparam logic signed [CB-1:0] ONE = CB'(1);
	localparam logic signed [CB-1:0] TWO = CB'(2);

	logic signed [CB-1:0] l_raw, t_raw, r_raw, b_raw;
	logic signed [CB-1:0] l, t, r, b;
	logic signed [CB-1:0] xs, ys, ps, ws, hs;
	logic                 en, in_cols, in_rows;
	logic                 top_band, bot_band, left_band, right_band;

	always_comb begin
		l_raw = CB'(signed'(rect[0*COORD_BITS +: COORD_BITS]));
		t_raw = CB'(signed'(rect[1*COORD_BITS +: COORD_BITS]));
		r_raw = CB'(signed'(rect[2*COORD_BITS +: COORD_BITS]));
		b_raw = CB'(signed'(rect[3*COORD_BITS +: COORD_BITS]));
		en    = rect[4*COORD_BITS];

		xs = CB'(signed'({1'b0, x}));
		ys = CB'(signed'({1'b0, y}));
		ps = CB'(signed'({1'b0, frame.pen}));
		ws = CB'(signed'({1'b0, frame.width}));
		hs = CB'(signed'({1'b0, frame.height}));

		// Keep the box one pixel inside the frame on every side.
		l = (l_raw < ONE) ? ONE : l_raw;
		t = (t_raw < ONE) ? ONE : t_raw;
		r = (r_raw >= ws - ONE) ? ws - TWO : r_raw;
		b = (b_raw >= hs - ONE) ? hs - TWO : b_raw;

		in_cols = (xs >= l) && (xs <= r - ONE);
		in_rows = (ys >= t) && (ys <= b - ONE);

		top_band   = in_cols && (ys >= t) && (ys <= t + ps - ONE) && (ys <= hs - ONE);
		bot_band   = in_cols && (ys >= b - ps + ONE) && (ys <= b);
		left_band  = in_rows && (xs >= l) && (xs <= l + ps - ONE) && (xs <= ws - ONE);
		right_band = in_rows && (xs >= r - ps + ONE) && (xs <= r);

		hit = en && (frame.pen != '0) && (top_band || bot_band || left_band || right_band);
	end

endmodule

// ===== hw/rtl/rect_outline_overlay.sv =====
// ----------------------------------------------------------------------------
// Rectangle outline overlay
// Replaces pixels that lie on the outline of any enabled rectangle with the
// configured drawing colour and passes all other pixels through.
// ----------------------------------------------------------------------------
// The block takes one pixel request per clock while the output is not
// stalled and returns one result request per pixel, in order, from the
// output register. A pixel is captured in the input register, all NUM_RECTS
// rectangles are tested in parallel in the single logic stage that follows,
// and the result is held in the output register; the input and output sides
// are parted by these two registers, so a new pixel is accepted while a
// finished result still waits to be taken. Configuration writes are accepted
// in every cycle and must only be issued while no pixel is in flight.
// Rectangles are clamped to stay one pixel inside the frame, and a pen width
// of zero disables drawing altogether.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rect_outline_overlay #(
	parameter int NUM_RECTS  = rect_ov_pkg::NUM_RECTS_DEF,
	parameter int COORD_BITS = rect_ov_pkg::COORD_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	rect_ov_pix_in_if.sink     pix_in,
	rect_ov_pix_out_if.source  pix_out,
	rect_ov_cfg_if.sink        cfg
);
	import rect_ov_pkg::*;

	localparam int RECT_BITS = rect_bits(COORD_BITS);

	logic [NUM_RECTS-1:0][RECT_BITS-1:0] rects;
	frame_cfg_t                          frame;
	logic [NUM_RECTS-1:0]                hit_vec;
	logic                                hit;

	// Input register.
	logic                 valid_s1;
	logic [PIX_BITS-1:0]  x_s1;
	logic [PIX_BITS-1:0]  y_s1;
	logic [CHAN_BITS-1:0] blue_s1;
	logic [CHAN_BITS-1:0] green_s1;
	logic [CHAN_BITS-1:0] red_s1;

	// Output register.
	logic                 valid_s2;
	logic [CHAN_BITS-1:0] blue_s2;
	logic [CHAN_BITS-1:0] green_s2;
	logic [CHAN_BITS-1:0] red_s2;
	logic                 on_outline_s2;

	logic ready_s1;
	logic load_s1;
	logic load_s2;

	rect_ov_cfg_regs #(
		.NUM_RECTS  (NUM_RECTS),
		.COORD_BITS (COORD_BITS)
	) u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.rects  (rects),
		.frame  (frame)
	);

	// One hit tester per rectangle; overlapping outlines use the same colour,
	// so a plain OR of the testers decides.
	for (genvar i = 0; i < NUM_RECTS; i++) begin : g_hit
		rect_ov_hit #(
			.COORD_BITS (COORD_BITS)
		) u_hit (
			.rect  (rects[i]),
			.x     (x_s1),
			.y     (y_s1),
			.frame (frame),
			.hit   (hit_vec[i])
		);
	end

	assign hit = |hit_vec;

	// The input register may advance whenever the output register is empty or
	// is being emptied in this cycle.
	assign ready_s1     = !valid_s2 || pix_out.ready;
	assign pix_in.ready = !valid_s1 || ready_s1;
	assign load_s1      = pix_in.valid && pix_in.ready;
	assign load_s2      = valid_s1 && ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (pix_in.ready) begin
				valid_s1 <= pix_in.valid;
			end
			if (ready_s1) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			x_s1     <= pix_in.pixel_x;
			y_s1     <= pix_in.pixel_y;
			blue_s1  <= pix_in.blue_in;
			green_s1 <= pix_in.green_in;
			red_s1   <= pix_in.red_in;
		end
		if (load_s2) begin
			on_outline_s2 <= hit;
			blue_s2       <= hit ? frame.color[23:16] : blue_s1;
			green_s2      <= hit ? frame.color[15:8]  : green_s1;
			red_s2        <= hit ? frame.color[7:0]   : red_s1;
		end
	end

	assign pix_out.valid      = valid_s2;
	assign pix_out.blue_out   = blue_s2;
	assign pix_out.green_out  = green_s2;
	assign pix_out.red_out    = red_s2;
	assign pix_out.on_outline = on_outline_s2;

	// A stalled pixel in the input register is neither lost nor overwritten.
	`RO_ASSERT_NXT(a_s1_hold, clk, arst_n, valid_s1 && !ready_s1, valid_s1 && $stable(x_s1), "input register lost a stalled pixel")
	// A pixel leaving the input register always lands in the output register.
	`RO_ASSERT_NXT(a_s1_to_s2, clk, arst_n, valid_s1 && ready_s1, valid_s2, "pixel dropped between stages")
	// An empty output register never holds back the input side.
	`RO_ASSERT_IMP(a_no_bubble_stall, clk, arst_n, !valid_s2, pix_in.ready, "input stalled with empty output register")
	// No rectangle may report a hit while the pen width is zero.
	`RO_ASSERT_IMP(a_pen_zero, clk, arst_n, hit, frame.pen != '0, "outline hit with zero pen width")

endmodule

// ===== tb/sv/tb_rect_outline_overlay.sv =====
// ----------------------------------------------------------------------------
// Rectangle outline overlay testbench
// Drives pixel requests and configuration writes into the overlay, predicts
// every result from an independent model of the outline bands, and checks
// each returned pixel in order under varying sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_rect_outline_overlay;
	timeunit 1ns;
	timeprecision 1ps;

	import rect_ov_pkg::*;

	// Widths and register indexes as the block sees them.
	localparam int N_RECT  = NUM_RECTS_DEF;
	localparam int CW      = COORD_BITS_DEF;
	localparam int RECT_W  = rect_bits(CW);
	localparam int DATA_W  = cfg_data_bits(CW);
	localparam int IDX_W   = cfg_index_bits(N_RECT);
	localparam int IDX_COLOR  = N_RECT + CFG_OFS_COLOR;
	localparam int IDX_PEN    = N_RECT + CFG_OFS_PEN;
	localparam int IDX_WIDTH  = N_RECT + CFG_OFS_WIDTH;
	localparam int IDX_HEIGHT = N_RECT + CFG_OFS_HEIGHT;

	// Two register stages between acceptance and the result.
	localparam int PIPE_LATENCY = 2;
	localparam int ITEMS_PER_PHASE = 120;
	localparam int NUM_PHASES = 10;

	// One result pixel as the output channel carries it.
	typedef struct {
		logic [CHAN_BITS-1:0] blue;
		logic [CHAN_BITS-1:0] green;
		logic [CHAN_BITS-1:0] red;
		logic                 on_outline;
	} overlay_px_t;

	// Keeps its own copy of the configuration, works out the overlaid pixel
	// for every accepted request and compares the returned pixels in order.
	class pixel_overlay_tracker;
		logic [RECT_W-1:0]     rects [N_RECT];
		logic [COLOR_BITS-1:0] color;
		logic [PEN_BITS-1:0]   pen;
		logic [FRAME_BITS-1:0] fw;
		logic [FRAME_BITS-1:0] fh;
		overlay_px_t           pending_px [$];
		int                    mismatches;

		function new();
			foreach (rects[i])
				rects[i] = '0;
			color = COLOR_RESET;
			pen = PEN_RESET;
			fw = WIDTH_RESET;
			fh = HEIGHT_RESET;
			mismatches = 0;
		endfunction

		function void set_reg(input int idx, input logic [DATA_W-1:0] data);
			if (idx < N_RECT) begin
				rects[idx] = data[RECT_W-1:0];
			end else begin
				case (idx)
					IDX_COLOR: color = data[COLOR_BITS-1:0];
					IDX_PEN: pen = data[PEN_BITS-1:0];
					IDX_WIDTH: fw = data[FRAME_BITS-1:0];
					IDX_HEIGHT: fh = data[FRAME_BITS-1:0];
					default: ;
				endcase
			end
		endfunction

		// Clamps the rectangle into the frame and tests the four bands.
		function bit on_bands(input logic [RECT_W-1:0] rv, input int x, input int y);
			int l, t, r, b, p, w, h;
			bit in_cols, in_rows;
			l = $signed(rv[0 +: CW]);
			t = $signed(rv[CW +: CW]);
			r = $signed(rv[2*CW +: CW]);
			b = $signed(rv[3*CW +: CW]);
			p = pen;
			w = fw;
			h = fh;
			if (l <= 0) l = 1;
			if (t <= 0) t = 1;
			if (r >= w - 1) r = w - 2;
			if (b >= h - 1) b = h - 2;
			in_cols = (x >= l) && (x <= r - 1);
			in_rows = (y >= t) && (y <= b - 1);
			if (in_cols && y >= t && y <= t + p - 1 && y <= h - 1) return 1'b1;
			if (in_cols && y >= b - p + 1 && y <= b) return 1'b1;
			if (in_rows && x >= l && x <= l + p - 1 && x <= w - 1) return 1'b1;
			if (in_rows && x >= r - p + 1 && x <= r) return 1'b1;
			return 1'b0;
		endfunction

		function void note_pixel(input logic [PIX_BITS-1:0] x, input logic [PIX_BITS-1:0] y,
				input logic [CHAN_BITS-1:0] b, input logic [CHAN_BITS-1:0] g,
				input logic [CHAN_BITS-1:0] r);
			overlay_px_t px;
			bit hit;
			hit = 1'b0;
			if (pen != '0) begin
				foreach (rects[i])
					if (rects[i][4*CW] && on_bands(rects[i], int'(x), int'(y)))
						hit = 1'b1;
			end
			if (hit) begin
				px.blue = color[23:16];
				px.green = color[15:8];
				px.red = color[7:0];
			end else begin
				px.blue = b;
				px.green = g;
				px.red = r;
			end
			px.on_outline = hit;
			pending_px.insert(pending_px.size(), px);
		endfunction

		function void check_result(input logic [CHAN_BITS-1:0] b, input logic [CHAN_BITS-1:0] g,
				input logic [CHAN_BITS-1:0] r, input logic o);
			overlay_px_t px;
			if (pending_px.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: b=%02h g=%02h r=%02h o=%0b", b, g, r, o);
				return;
			end
			px = pending_px.pop_front();
			if (b !== px.blue || g !== px.green || r !== px.red || o !== px.on_outline) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: expected b=%02h g=%02h r=%02h o=%0b, got b=%02h g=%02h r=%02h o=%0b",
						px.blue, px.green, px.red, px.on_outline, b, g, r, o);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	rect_ov_pix_in_if  pix_in_bus ();
	rect_ov_pix_out_if pix_out_bus ();
	rect_ov_cfg_if     cfg_bus ();

	rect_outline_overlay u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.pix_in  (pix_in_bus),
		.pix_out (pix_out_bus),
		.cfg     (cfg_bus)
	);

	pixel_overlay_tracker tracker = new();

	// Idling percentages of the current phase, and a pending long hold-off of
	// the receiver in cycles, which the receiver process picks up itself.
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_req = 0;

	// The rectangles of the current scene, kept to aim pixels at their edges.
	int sc_l [N_RECT];
	int sc_t [N_RECT];
	int sc_r [N_RECT];
	int sc_b [N_RECT];
	int scene_pen, scene_fw, scene_fh;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Packs four signed coordinates and the enable into one rectangle register.
	function automatic logic [DATA_W-1:0] pack_rect(input int l, input int t, input int r,
			input int b, input bit en);
		logic [RECT_W-1:0] v;
		v = {en, b[CW-1:0], r[CW-1:0], t[CW-1:0], l[CW-1:0]};
		return DATA_W'(v);
	endfunction

	// Leaves valid high after the write; the caller lowers it after a group of
	// writes, so that valid is never lowered and raised within one step.
	task automatic write_reg(input int idx, input logic [DATA_W-1:0] data);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx[IDX_W-1:0];
		cfg_bus.data <= data;
		do @(posedge clk); while (!cfg_bus.ready);
		tracker.set_reg(idx, data);
	endtask

	// Offers one pixel request, after a random gap in the current phase, and
	// returns at the edge on which it was taken, with valid still high.
	task automatic send_pixel(input logic [PIX_BITS-1:0] x, input logic [PIX_BITS-1:0] y,
			input logic [CHAN_BITS-1:0] b, input logic [CHAN_BITS-1:0] g,
			input logic [CHAN_BITS-1:0] r);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			pix_in_bus.valid <= 1'b0;
			@(posedge clk);
		end
		pix_in_bus.valid <= 1'b1;
		pix_in_bus.pixel_x <= x;
		pix_in_bus.pixel_y <= y;
		pix_in_bus.blue_in <= b;
		pix_in_bus.green_in <= g;
		pix_in_bus.red_in <= r;
		do @(posedge clk); while (!pix_in_bus.ready);
		tracker.note_pixel(x, y, b, g, r);
	endtask

	task automatic send_xy(input int x, input int y);
		send_pixel(x[PIX_BITS-1:0], y[PIX_BITS-1:0], CHAN_BITS'($urandom_range(0, 255)),
			CHAN_BITS'($urandom_range(0, 255)), CHAN_BITS'($urandom_range(0, 255)));
	endtask

	// Stops offering and waits until every predicted pixel has come back.
	task automatic wait_for_results();
		pix_in_bus.valid <= 1'b0;
		while (tracker.pending_px.size() != 0)
			@(posedge clk);
	endtask

	// Configuration may only change with nothing in flight, so the task waits
	// on past the last result before any write.
	task automatic quiesce();
		wait_for_results();
		repeat (PIPE_LATENCY + 2) @(posedge clk);
	endtask

	// Draws and writes a whole scene. Kind 0 is an ordinary frame with a few
	// boxes, kind 1 a 4096x4096 frame with the widest pen and boxes reaching
	// past its edges, kind 2 the same as 0 with the pen width at zero, kind 3 a
	// frame of almost no size, and kind 4 registers with every bit random.
	task automatic random_scene(input int kind);
		int l, t, r, b, rw, rh;
		bit en;
		logic [COLOR_BITS-1:0] col;
		col = COLOR_BITS'($urandom_range(0, 24'hFFFFFF));
		scene_fw = $urandom_range(16, 400);
		scene_fh = $urandom_range(16, 400);
		scene_pen = $urandom_range(1, 6);
		case (kind)
			1: begin
				scene_fw = 4096;
				scene_fh = 4096;
				scene_pen = 63;
				col = 24'hFFFFFF;
			end
			2: scene_pen = 0;
			3: begin
				scene_fw = $urandom_range(0, 3);
				scene_fh = $urandom_range(0, 3);
				col = '0;
			end
			4: begin
				scene_fw = $urandom_range(0, 8191);
				scene_fh = $urandom_range(0, 8191);
				scene_pen = $urandom_range(0, 63);
			end
			default: ;
		endcase
		for (int i = 0; i < N_RECT; i++) begin
			case (kind)
				1: begin
					l = int'($urandom_range(0, 200)) - 100;
					t = int'($urandom_range(0, 200)) - 100;
					r = $urandom_range(3800, 4095);
					b = $urandom_range(3800, 4095);
					en = 1'b1;
				end
				3: begin
					l = int'($urandom_range(0, 6)) - 2;
					t = int'($urandom_range(0, 6)) - 2;
					r = int'($urandom_range(0, 6)) - 2;
					b = int'($urandom_range(0, 6)) - 2;
					en = 1'b1;
				end
				4: begin
					l = int'($urandom_range(0, 8191)) - 4096;
					t = int'($urandom_range(0, 8191)) - 4096;
					r = int'($urandom_range(0, 8191)) - 4096;
					b = int'($urandom_range(0, 8191)) - 4096;
					en = $urandom_range(0, 1);
				end
				default: begin
					l = int'($urandom_range(0, scene_fw)) - 8;
					t = int'($urandom_range(0, scene_fh)) - 8;
					rw = $urandom_range(0, scene_fw / 2);
					rh = $urandom_range(0, scene_fh / 2);
					// Now and then the box is turned inside out.
					r = ($urandom_range(0, 7) == 0) ? l - rw : l + rw;
					b = ($urandom_range(0, 7) == 0) ? t - rh : t + rh;
					en = ($urandom_range(0, 9) != 0);
				end
			endcase
			sc_l[i] = l;
			sc_t[i] = t;
			sc_r[i] = r;
			sc_b[i] = b;
			write_reg(i, pack_rect(l, t, r, b, en));
		end
		write_reg(IDX_COLOR, DATA_W'(col));
		write_reg(IDX_PEN, DATA_W'(scene_pen));
		write_reg(IDX_WIDTH, DATA_W'(scene_fw));
		write_reg(IDX_HEIGHT, DATA_W'(scene_fh));
		cfg_bus.valid <= 1'b0;
	endtask

	// Most pixels are aimed at the edges of one of the scene's boxes, where
	// the band limits are decided; the rest fall anywhere in the frame or
	// anywhere in the coordinate range.
	task automatic send_scene_pixel();
		int sel, i, d, lo, hi, x, y;
		sel = $urandom_range(0, 99);
		i = $urandom_range(0, N_RECT - 1);
		d = scene_pen + 3;
		if (sel < 70) begin
			case ($urandom_range(0, 3))
				0: x = sc_l[i] + int'($urandom_range(0, 2 * d)) - d;
				1: x = sc_r[i] + int'($urandom_range(0, 2 * d)) - d;
				default: begin
					lo = (sc_l[i] < sc_r[i]) ? sc_l[i] : sc_r[i];
					hi = (sc_l[i] < sc_r[i]) ? sc_r[i] : sc_l[i];
					x = lo - 2 + int'($urandom_range(0, hi - lo + 4));
				end
			endcase
			if (x == sc_l[i] - d || $urandom_range(0, 1) == 0) begin
				case ($urandom_range(0, 1))
					0: y = sc_t[i] + int'($urandom_range(0, 2 * d)) - d;
					default: y = sc_b[i] + int'($urandom_range(0, 2 * d)) - d;
				endcase
			end else begin
				lo = (sc_t[i] < sc_b[i]) ? sc_t[i] : sc_b[i];
				hi = (sc_t[i] < sc_b[i]) ? sc_b[i] : sc_t[i];
				y = lo - 2 + int'($urandom_range(0, hi - lo + 4));
			end
		end else if (sel < 85) begin
			x = $urandom_range(0, scene_fw + 1);
			y = $urandom_range(0, scene_fh + 1);
		end else begin
			x = $urandom_range(0, 4095);
			y = $urandom_range(0, 4095);
		end
		send_xy(x, y);
	endtask

	// Stimulus and the end of the run.
	initial begin
		arst_n <= 1'b0;
		pix_in_bus.valid <= 1'b0;
		pix_in_bus.pixel_x <= '0;
		pix_in_bus.pixel_y <= '0;
		pix_in_bus.blue_in <= '0;
		pix_in_bus.green_in <= '0;
		pix_in_bus.red_in <= '0;
		cfg_bus.valid <= 1'b0;
		cfg_bus.index <= '0;
		cfg_bus.data <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// With the registers as they come out of reset every box is disabled,
		// so the extremes of the coordinates and channels pass straight through.
		send_pixel('0, '0, '0, '0, '0);
		send_pixel('1, '1, '1, '1, '1);
		quiesce();

		// Two overlapping boxes, a disabled one, and one reaching far outside
		// the frame, so that the clamp puts its outline one pixel inside the frame.
		write_reg(0, pack_rect(10, 20, 50, 40, 1'b1));
		write_reg(1, pack_rect(30, 30, 70, 60, 1'b1));
		write_reg(2, pack_rect(100, 100, 120, 120, 1'b0));
		write_reg(3, pack_rect(-100, -1, 4095, 4095, 1'b1));
		write_reg(IDX_COLOR, DATA_W'(24'hA5C3FF));
		write_reg(IDX_PEN, DATA_W'(4));
		write_reg(IDX_WIDTH, DATA_W'(640));
		write_reg(IDX_HEIGHT, DATA_W'(480));
		cfg_bus.valid <= 1'b0;
		send_xy(10, 20);
		send_xy(49, 20);
		send_xy(50, 40);
		send_xy(9, 25);
		send_xy(13, 25);
		send_xy(14, 25);
		send_xy(32, 38);
		send_xy(110, 100);
		send_xy(1, 1);
		send_xy(638, 300);
		send_xy(639, 300);
		send_xy(300, 478);
		send_xy(300, 479);
		send_xy(4095, 10);
		send_xy(700, 2);
		quiesce();

		// A pen width of zero draws nothing, even on the border.
		write_reg(IDX_PEN, DATA_W'(0));
		cfg_bus.valid <= 1'b0;
		send_xy(10, 20);
		send_xy(1, 1);
		quiesce();

		// A frame of zero size pushes the clamped right and bottom bounds below zero.
		write_reg(IDX_PEN, DATA_W'(63));
		write_reg(IDX_WIDTH, DATA_W'(0));
		write_reg(IDX_HEIGHT, DATA_W'(0));
		cfg_bus.valid <= 1'b0;
		send_xy(1, 1);
		send_xy(0, 0);

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			quiesce();
			case (ph % 4)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 67;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 67;
				end
				default: begin
					send_idle_pct = 36;
					recv_stall_pct = 36;
				end
			endcase
			random_scene(ph % 5);
			// A long stall of the receiver while requests keep coming fills
			// both registers and must hold the input back.
			if (ph == 4)
				hold_req = 300;
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				// Halfway through one phase the sender stops until the block
				// has emptied completely, then carries on.
				if (ph == 6 && n == ITEMS_PER_PHASE / 2)
					wait_for_results();
				send_scene_pixel();
			end
		end

		wait_for_results();
		repeat (PIPE_LATENCY * 4) @(posedge clk);
		if (tracker.mismatches == 0 && tracker.pending_px.size() == 0)
			$display("tb_rect_outline_overlay: PASS");
		else
			$display("tb_rect_outline_overlay: FAIL");
		$finish;
	end

	// The receiver: checks each taken result and stalls at random, or for a
	// long stretch when one is asked for.
	initial begin : receiver
		int hold_left;
		hold_left = 0;
		pix_out_bus.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && pix_out_bus.valid && pix_out_bus.ready)
				tracker.check_result(pix_out_bus.blue_out, pix_out_bus.green_out,
					pix_out_bus.red_out, pix_out_bus.on_outline);
			if (hold_left > 0) begin
				hold_left--;
				pix_out_bus.ready <= 1'b0;
			end else if (hold_req > 0) begin
				hold_left = hold_req - 1;
				hold_req = 0;
				pix_out_bus.ready <= 1'b0;
			end else begin
				pix_out_bus.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
			end
		end
	end

	// A run that hangs is a failure; the slowest correct run is far shorter.
	initial begin
		#5ms;
		$display("tb_rect_outline_overlay: FAIL");
		$finish;
	end

endmodule

// ===== rect_outline_overlay.f =====
+incdir+hw/rtl
hw/rtl/rect_ov_pkg.sv
hw/rtl/rect_ov_if.sv
hw/rtl/rect_ov_cfg_regs.sv
hw/rtl/rect_ov_hit.sv
hw/rtl/rect_outline_overlay.sv
tb/sv/tb_rect_outline_overlay.sv
